// ===== hw/rtl/fntu_pkg.sv =====
package fntu_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SQRT_IN_W  = 64;
  localparam int unsigned SQRT_STEPS = SQRT_IN_W / 2;
  localparam int unsigned DIV_NUM_W  = 62;
  localparam int unsigned DIV_DEN_W  = 32;
  localparam int unsigned DIV_Q_W    = 31;

  localparam logic signed [DATA_W-1:0] THRESH_RAW = 32'sd6554;
  localparam logic [DIV_Q_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] FIXED_NORM_RESET = 31'd65536;

  typedef enum logic [0:0] {
    REG_FIXED_NORM = 1'b0
  } reg_idx_t;

endpackage

// ===== hw/rtl/fntu_delay.sv =====
module fntu_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < int'(DEPTH); k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// ===== hw/rtl/fntu_sqrt.sv =====
module fntu_sqrt #(
  parameter int unsigned IN_W = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int unsigned STEPS = IN_W / 2;

  logic [IN_W-1:0] rem [STEPS];
  logic [IN_W-1:0] res [STEPS];
  logic [IN_W-1:0] rem_src [STEPS];
  logic [IN_W-1:0] res_src [STEPS];
  logic [IN_W-1:0] rem_next [STEPS];
  logic [IN_W-1:0] res_next [STEPS];

  always_comb begin
    rem_src[0] = rad;
    res_src[0] = '0;
    for (int k = 1; k < int'(STEPS); k++) begin
      rem_src[k] = rem[k-1];
      res_src[k] = res[k-1];
    end
  end

  // one result bit per stage, trial bit walks down two places each step
  always_comb begin
    logic [IN_W-1:0] bitv;
    logic [IN_W:0]   trial;
    for (int k = 0; k < int'(STEPS); k++) begin
      bitv  = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * k);
      trial = {1'b0, res_src[k]} + {1'b0, bitv};
      if ({1'b0, rem_src[k]} >= trial) begin
        rem_next[k] = rem_src[k] - trial[IN_W-1:0];
        res_next[k] = (res_src[k] >> 1) + bitv;
      end else begin
        rem_next[k] = rem_src[k];
        res_next[k] = res_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      res <= res_next;
    end
  end

  assign root = res[STEPS-1][IN_W/2-1:0];

endmodule

// ===== hw/rtl/fntu_div.sv =====
module fntu_div #(
  parameter int unsigned NUM_W = 62,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  // restoring division, one quotient bit per stage; needs num < den << Q_W
  logic [DEN_W-1:0] rem [Q_W];
  logic [Q_W-1:0]   low [Q_W];
  logic [DEN_W-1:0] dv  [Q_W];
  logic [Q_W-1:0]   qt  [Q_W];
  logic [DEN_W-1:0] rem_src [Q_W];
  logic [Q_W-1:0]   low_src [Q_W];
  logic [DEN_W-1:0] dv_src  [Q_W];
  logic [Q_W-1:0]   qt_src  [Q_W];
  logic [DEN_W-1:0] rem_next [Q_W];
  logic [Q_W-1:0]   qt_next  [Q_W];

  always_comb begin
    rem_src[0] = DEN_W'(num[NUM_W-1:Q_W]);
    low_src[0] = num[Q_W-1:0];
    dv_src[0]  = den;
    qt_src[0]  = '0;
    for (int k = 1; k < int'(Q_W); k++) begin
      rem_src[k] = rem[k-1];
      low_src[k] = low[k-1];
      dv_src[k]  = dv[k-1];
      qt_src[k]  = qt[k-1];
    end
  end

  always_comb begin
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    for (int k = 0; k < int'(Q_W); k++) begin
      t    = {rem_src[k], low_src[k][Q_W-1]};
      diff = t - {1'b0, dv_src[k]};
      if (t >= {1'b0, dv_src[k]}) begin
        rem_next[k] = diff[DEN_W-1:0];
        qt_next[k]  = {qt_src[k][Q_W-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DEN_W-1:0];
        qt_next[k]  = {qt_src[k][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      qt  <= qt_next;
      dv  <= dv_src;
      for (int k = 0; k < int'(Q_W); k++) begin
        low[k] <= low_src[k] << 1;
      end
    end
  end

  assign quo = qt[Q_W-1];

endmodule

// ===== hw/rtl/fixed_norm_tangent_update_top.sv =====
// throughput: one item per cycle, every unit is fully pipelined; the latency comes mostly
// from two square root passes (32 stages each) and two divider passes (31 stages each)
// a result stalled on the master side freezes the whole pipeline and input tready
// reset clears all valid bits and sets fixed_norm to 1.0 (65536)
module fixed_norm_tangent_update_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // point_x, point_y, point_z, step_a, step_b
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // result_x, result_y, result_z
  output logic [0:0]   m_tuser,   // degenerate
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned SQ  = fntu_pkg::SQRT_STEPS;
  localparam int unsigned DV  = fntu_pkg::DIV_Q_W;
  localparam int unsigned LAT = 2 + SQ + 1 + DV + 13 + SQ + 1 + DV + 2;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sgn32(input logic [30:0] q, input logic neg);
    logic [31:0] t;
    t = {1'b0, q};
    return neg ? (~t + 32'd1) : t;
  endfunction

  // configuration
  logic [30:0] fixed_norm;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_norm <= fntu_pkg::FIXED_NORM_RESET;
    end else if (cfg_wr && paddr[2] == fntu_pkg::REG_FIXED_NORM) begin
      fixed_norm <= pwdata[30:0];
    end
  end

  always_comb begin
    unique case (fntu_pkg::reg_idx_t'(paddr[2]))
      fntu_pkg::REG_FIXED_NORM: prdata = {1'b0, fixed_norm};
      default:                  prdata = '0;
    endcase
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic signed [31:0] in_pt [3];
  logic signed [31:0] in_a, in_b;
  logic               wide_in;

  assign in_pt[0] = s_tdata[31:0];
  assign in_pt[1] = s_tdata[63:32];
  assign in_pt[2] = s_tdata[95:64];
  assign in_a     = s_tdata[127:96];
  assign in_b     = s_tdata[159:128];

  // cross with the x axis when y or z is clearly away from zero
  assign wide_in = (in_pt[1] > fntu_pkg::THRESH_RAW) || (in_pt[1] < -fntu_pkg::THRESH_RAW) ||
                   (in_pt[2] > fntu_pkg::THRESH_RAW) || (in_pt[2] < -fntu_pkg::THRESH_RAW);

  // stages 1-2: squares and sums for both norms
  logic signed [31:0] pt_s1 [3];
  logic signed [31:0] a_s1, b_s1;
  logic               wide_s1;
  logic [63:0]        sq_s1 [3];
  logic [63:0]        sqe_s2, sqp_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt_s1[i] <= in_pt[i];
        sq_s1[i] <= in_pt[i] * in_pt[i];
      end
      a_s1    <= in_a;
      b_s1    <= in_b;
      wide_s1 <= wide_in;
      sqe_s2  <= wide_s1 ? (sq_s1[1] + sq_s1[2]) : (sq_s1[2] + sq_s1[0]);
      sqp_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
    end
  end

  logic [31:0]  n1_s34, nx_s34;
  logic [160:0] side_s34;

  fntu_sqrt #(.IN_W(fntu_pkg::SQRT_IN_W)) u_sqrt_e1 (
    .clk(clk), .en(en), .rad(sqe_s2), .root(n1_s34)
  );

  fntu_sqrt #(.IN_W(fntu_pkg::SQRT_IN_W)) u_sqrt_pt (
    .clk(clk), .en(en), .rad(sqp_s2), .root(nx_s34)
  );

  fntu_delay #(.W(161), .DEPTH(SQ + 1)) u_dly_sqrt0 (
    .clk(clk), .en(en),
    .d({pt_s1[2], pt_s1[1], pt_s1[0], a_s1, b_s1, wide_s1}),
    .q(side_s34)
  );

  logic signed [31:0] pt_s34 [3];
  logic signed [31:0] a_s34, b_s34;
  logic               wide_s34;

  assign {pt_s34[2], pt_s34[1], pt_s34[0], a_s34, b_s34, wide_s34} = side_s34;

  // stage 35: divider numerators for the two unit vectors
  logic [31:0] e1mag [3];
  logic [61:0] nume_s35 [3];
  logic [61:0] numx_s35 [3];
  logic [31:0] n1_s35, nx_s35;
  logic signed [31:0] pt_s35 [3];
  logic signed [31:0] a_s35, b_s35;
  logic        wide_s35, deg_s35;

  always_comb begin
    e1mag[0] = wide_s34 ? 32'd0 : mag32(pt_s34[2]);
    e1mag[1] = wide_s34 ? mag32(pt_s34[2]) : 32'd0;
    e1mag[2] = wide_s34 ? mag32(pt_s34[1]) : mag32(pt_s34[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nume_s35[i] <= {e1mag[i], 30'd0} + {31'd0, n1_s34[31:1]};
        numx_s35[i] <= {mag32(pt_s34[i]), 30'd0} + {31'd0, nx_s34[31:1]};
        pt_s35[i]   <= pt_s34[i];
      end
      n1_s35   <= n1_s34;
      nx_s35   <= nx_s34;
      a_s35    <= a_s34;
      b_s35    <= b_s34;
      wide_s35 <= wide_s34;
      deg_s35  <= (n1_s34 == 32'd0) || (nx_s34 == 32'd0);
    end
  end

  logic [30:0]  qe_s66 [3];
  logic [30:0]  qx_s66 [3];
  logic [161:0] side_s66;

  for (genvar g = 0; g < 3; g++) begin : g_unit
    fntu_div #(
      .NUM_W(fntu_pkg::DIV_NUM_W), .DEN_W(fntu_pkg::DIV_DEN_W), .Q_W(fntu_pkg::DIV_Q_W)
    ) u_div_e1 (
      .clk(clk), .en(en), .num(nume_s35[g]), .den(n1_s35), .quo(qe_s66[g])
    );
    fntu_div #(
      .NUM_W(fntu_pkg::DIV_NUM_W), .DEN_W(fntu_pkg::DIV_DEN_W), .Q_W(fntu_pkg::DIV_Q_W)
    ) u_div_pt (
      .clk(clk), .en(en), .num(numx_s35[g]), .den(nx_s35), .quo(qx_s66[g])
    );
  end

  fntu_delay #(.W(162), .DEPTH(DV)) u_dly_div0 (
    .clk(clk), .en(en),
    .d({pt_s35[2], pt_s35[1], pt_s35[0], a_s35, b_s35, wide_s35, deg_s35}),
    .q(side_s66)
  );

  logic signed [31:0] pt_s66 [3];
  logic signed [31:0] a_s66, b_s66;
  logic               wide_s66, deg_s66;
  logic [2:0]         e1neg;

  assign {pt_s66[2], pt_s66[1], pt_s66[0], a_s66, b_s66, wide_s66, deg_s66} = side_s66;

  always_comb begin
    e1neg[0] = wide_s66 ? 1'b0 : (pt_s66[2] > 32'sd0);
    e1neg[1] = wide_s66 ? (pt_s66[2] < 32'sd0) : 1'b0;
    e1neg[2] = wide_s66 ? (pt_s66[1] > 32'sd0) : (pt_s66[0] < 32'sd0);
  end

  // stages 67-72: second basis vector and the tangent sum
  logic signed [31:0] e1_s67 [3];
  logic signed [31:0] ux_s67 [3];
  logic signed [31:0] pt_s67 [3], pt_s68 [3], pt_s69 [3], pt_s70 [3], pt_s71 [3];
  logic signed [31:0] a_s67, b_s67, b_s68, b_s69, b_s70;
  logic               deg_s67, deg_s68, deg_s69, deg_s70, deg_s71, deg_s72;
  logic signed [63:0] cp_s68 [6];
  logic signed [63:0] ae_s68 [3], ae_s69 [3], ae_s70 [3], ae_s71 [3];
  logic signed [63:0] d_s69 [3];
  logic signed [31:0] e2_s70 [3];
  logic signed [31:0] e2_next [3];
  logic signed [63:0] be_s71 [3];
  logic signed [63:0] p_s72 [3];

  // round the q4.60 cross product to q2.30, ties away from zero, clamp to one
  always_comb begin
    logic [63:0] dm;
    logic [63:0] rr;
    for (int i = 0; i < 3; i++) begin
      dm = d_s69[i][63] ? (~d_s69[i] + 64'd1) : d_s69[i];
      rr = (dm + 64'h2000_0000) >> 30;
      if (rr > 64'h4000_0000) begin
        rr = 64'h4000_0000;
      end
      e2_next[i] = sgn32(rr[30:0], d_s69[i][63]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_s67[i] <= sgn32(qe_s66[i], e1neg[i]);
        ux_s67[i] <= sgn32(qx_s66[i], pt_s66[i][31]);
        pt_s67[i] <= pt_s66[i];
        ae_s68[i] <= a_s67 * e1_s67[i];
        pt_s68[i] <= pt_s67[i];
        ae_s69[i] <= ae_s68[i];
        pt_s69[i] <= pt_s68[i];
        e2_s70[i] <= e2_next[i];
        ae_s70[i] <= ae_s69[i];
        pt_s70[i] <= pt_s69[i];
        be_s71[i] <= b_s70 * e2_s70[i];
        ae_s71[i] <= ae_s70[i];
        pt_s71[i] <= pt_s70[i];
        p_s72[i]  <= {{2{pt_s71[i][31]}}, pt_s71[i], 30'd0} + ae_s71[i] + be_s71[i];
      end
      a_s67   <= a_s66;
      b_s67   <= b_s66;
      deg_s67 <= deg_s66;
      cp_s68[0] <= ux_s67[1] * e1_s67[2];
      cp_s68[1] <= ux_s67[2] * e1_s67[1];
      cp_s68[2] <= ux_s67[2] * e1_s67[0];
      cp_s68[3] <= ux_s67[0] * e1_s67[2];
      cp_s68[4] <= ux_s67[0] * e1_s67[1];
      cp_s68[5] <= ux_s67[1] * e1_s67[0];
      b_s68   <= b_s67;
      deg_s68 <= deg_s67;
      d_s69[0] <= cp_s68[0] - cp_s68[1];
      d_s69[1] <= cp_s68[2] - cp_s68[3];
      d_s69[2] <= cp_s68[4] - cp_s68[5];
      b_s69   <= b_s68;
      deg_s69 <= deg_s68;
      b_s70   <= b_s69;
      deg_s70 <= deg_s69;
      deg_s71 <= deg_s70;
      deg_s72 <= deg_s71;
    end
  end

  // stages 73-79: block normalize the magnitudes to 31 bits, sum of squares
  logic [63:0] m_s73 [3], m_s74 [3], m_s75 [3];
  logic [2:0]  neg_s73, neg_s74, neg_s75, neg_s76, neg_s77, neg_s78, neg_s79;
  logic        deg_s73, deg_s74, deg_s75, deg_s76, deg_s77, deg_s78, deg_s79;
  logic [63:0] big_s74;
  logic [6:0]  len_next, len_s75, len_s76;
  logic [64:0] mr_s76 [3];
  logic [31:0] ms_next [3];
  logic [31:0] ms_s77 [3], ms_s78 [3], ms_s79 [3];
  logic [63:0] sqm_s78 [3];
  logic [63:0] sqs_s79;

  always_comb begin
    len_next = '0;
    for (int k = 0; k < 64; k++) begin
      if (big_s74[k]) begin
        len_next = 7'(k + 1);
      end
    end
  end

  always_comb begin
    logic [64:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = (len_s76 > 7'd31) ? (mr_s76[i] >> (len_s76 - 7'd31))
                             : (mr_s76[i] << (7'd31 - len_s76));
      ms_next[i] = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_s73[i]   <= p_s72[i][63] ? (~p_s72[i] + 64'd1) : p_s72[i];
        neg_s73[i] <= p_s72[i][63];
        m_s74[i]   <= m_s73[i];
        m_s75[i]   <= m_s74[i];
        mr_s76[i]  <= (len_s75 > 7'd31)
                      ? ({1'b0, m_s75[i]} + (65'd1 << (len_s75 - 7'd32)))
                      : {1'b0, m_s75[i]};
        ms_s77[i]  <= ms_next[i];
        sqm_s78[i] <= ms_s77[i] * ms_s77[i];
        ms_s78[i]  <= ms_s77[i];
        ms_s79[i]  <= ms_s78[i];
      end
      deg_s73 <= deg_s72;
      big_s74 <= m_s73[0] | m_s73[1] | m_s73[2];
      neg_s74 <= neg_s73;
      deg_s74 <= deg_s73;
      len_s75 <= len_next;
      neg_s75 <= neg_s74;
      deg_s75 <= deg_s74 || (big_s74 == 64'd0);
      len_s76 <= len_s75;
      neg_s76 <= neg_s75;
      deg_s76 <= deg_s75;
      neg_s77 <= neg_s76;
      deg_s77 <= deg_s76;
      neg_s78 <= neg_s77;
      deg_s78 <= deg_s77;
      sqs_s79 <= sqm_s78[0] + sqm_s78[1] + sqm_s78[2];
      neg_s79 <= neg_s78;
      deg_s79 <= deg_s78;
    end
  end

  logic [31:0] nq_s111;
  logic [99:0] side_s111;

  fntu_sqrt #(.IN_W(fntu_pkg::SQRT_IN_W)) u_sqrt_sum (
    .clk(clk), .en(en), .rad(sqs_s79), .root(nq_s111)
  );

  fntu_delay #(.W(100), .DEPTH(SQ)) u_dly_sqrt1 (
    .clk(clk), .en(en),
    .d({ms_s79[2], ms_s79[1], ms_s79[0], neg_s79, deg_s79}),
    .q(side_s111)
  );

  logic [31:0] ms_s111 [3];
  logic [2:0]  neg_s111;
  logic        deg_s111;

  assign {ms_s111[2], ms_s111[1], ms_s111[0], neg_s111, deg_s111} = side_s111;

  // stage 112: numerators for the final unit vector
  logic [61:0] numq_s112 [3];
  logic [31:0] nq_s112;
  logic [2:0]  neg_s112;
  logic        deg_s112;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        numq_s112[i] <= {ms_s111[i][31:0], 30'd0} + {31'd0, nq_s111[31:1]};
      end
      nq_s112  <= nq_s111;
      neg_s112 <= neg_s111;
      deg_s112 <= deg_s111 || (nq_s111 == 32'd0);
    end
  end

  logic [30:0] u_s143 [3];
  logic [3:0]  side_s143;

  for (genvar g = 0; g < 3; g++) begin : g_out
    fntu_div #(
      .NUM_W(fntu_pkg::DIV_NUM_W), .DEN_W(fntu_pkg::DIV_DEN_W), .Q_W(fntu_pkg::DIV_Q_W)
    ) u_div_out (
      .clk(clk), .en(en), .num(numq_s112[g]), .den(nq_s112), .quo(u_s143[g])
    );
  end

  fntu_delay #(.W(4), .DEPTH(DV)) u_dly_div1 (
    .clk(clk), .en(en), .d({neg_s112, deg_s112}), .q(side_s143)
  );

  // stages 144-145: scale to fixed_norm, round, saturate, zero degenerate results
  logic [61:0]        pr_s144 [3];
  logic [2:0]         neg_s144;
  logic               deg_s144;
  logic signed [31:0] res_next [3];
  logic signed [31:0] res_s145 [3];
  logic               deg_s145;

  always_comb begin
    logic [62:0] rr;
    for (int i = 0; i < 3; i++) begin
      rr = ({1'b0, pr_s144[i]} + 63'h2000_0000) >> 30;
      if (deg_s144) begin
        res_next[i] = '0;
      end else if (neg_s144[i]) begin
        if (rr > 63'h8000_0000) begin
          rr = 63'h8000_0000;
        end
        res_next[i] = ~rr[31:0] + 32'd1;
      end else begin
        if (rr > 63'h7FFF_FFFF) begin
          rr = 63'h7FFF_FFFF;
        end
        res_next[i] = rr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_s144[i]  <= u_s143[i] * fixed_norm;
        res_s145[i] <= res_next[i];
      end
      {neg_s144, deg_s144} <= side_s143;
      deg_s145 <= deg_s144;
    end
  end

  assign m_tdata = {res_s145[2], res_s145[1], res_s145[0]};
  assign m_tuser = deg_s145;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("degenerate result carries nonzero coordinates");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (vld[65] && !deg_s66) |->
      (qe_s66[0] <= fntu_pkg::ONE_Q30 && qe_s66[1] <= fntu_pkg::ONE_Q30 &&
       qe_s66[2] <= fntu_pkg::ONE_Q30 && qx_s66[0] <= fntu_pkg::ONE_Q30 &&
       qx_s66[1] <= fntu_pkg::ONE_Q30 && qx_s66[2] <= fntu_pkg::ONE_Q30))
    else $error("unit vector component above one");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (vld[76] && !deg_s77) |->
      ((ms_s77[0] | ms_s77[1] | ms_s77[2]) >= 32'h4000_0000 &&
       ms_s77[0] <= 32'h8000_0000 && ms_s77[1] <= 32'h8000_0000 &&
       ms_s77[2] <= 32'h8000_0000))
    else $error("block normalization out of range");

endmodule
